/* design/ght_pkg.sv */
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and codes for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  typedef enum logic [2:0] {
    ACT_ALLOC_CTX = 3'd0,
    ACT_ALLOC_PRB = 3'd1,
    ACT_GET_CTX   = 3'd2,
    ACT_GET_PRB   = 3'd3,
    ACT_REL_PRB   = 3'd4,
    ACT_REL_CTX   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_STALE   = 3'd2,
    ST_TYPE    = 3'd3,
    ST_OWNER   = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_CTX  = 2'd1,
    KIND_PRB  = 2'd2
  } kind_t;

  localparam int unsigned GEN_W = 31;
  localparam logic [GEN_W-1:0] GEN_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]       kind;
    logic [GEN_W-1:0] gen;
    logic [63:0]      owner;
  } slot_t;

endpackage

/* design/generational_handle_table.sv */
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot table issuing generation-tagged handles for contexts and probes.
// ----------------------------------------------------------------------------
// operation: gets and probe releases check the handle and read its slot; allocation
//   scans created slots for a free one, else takes a new slot; context release
//   also frees every probe owned by the context (owned-probe scan)
// throughput: one request at a time, busy high until the result strobe
// reset: synchronous clearing pass over the slot memory, busy high meanwhile;
//   the receiver cannot stall results
module generational_handle_table #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_handle,
  input  logic [63:0] in_owner,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [62:0] out_new_handle,
  output logic [63:0] out_found_payload,
  output logic [6:0]  out_live_contexts,
  output logic [6:0]  out_live_probes,
  output logic [63:0] out_allocations_total,
  output logic [63:0] out_releases_total
);
  import ght_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_CHKW  = 10'b0000001000,
    S_SRD   = 10'b0000010000,
    S_SCHK  = 10'b0000100000,
    S_ALLOC = 10'b0001000000,
    S_CSCAN = 10'b0010000000,
    S_CFIN  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  slot_t       slot_mem [SLOT_COUNT];
  logic [63:0] val_mem  [SLOT_COUNT];

  state_t           state_r, state_nxt;
  logic [IW-1:0]    rd_addr;
  logic             we;
  logic [IW-1:0]    wr_addr;
  slot_t            wr_data;
  slot_t            rd_q;
  logic [63:0]      val_q;
  logic             vwe;

  logic [2:0]       act_r;
  logic [63:0]      hdl_r, own_r, pay_r;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    created_r, created_nxt;
  logic [6:0]       ctx_r, ctx_nxt, prb_r, prb_nxt;
  logic [63:0]      alc_r, alc_nxt, rel_r, rel_nxt;
  logic [2:0]       st_r, st_nxt;
  logic [62:0]      nh_r, nh_nxt;
  logic [63:0]      fp_r, fp_nxt;
  logic             ov_r;

  logic [31:0]      h_low;
  logic [GEN_W-1:0] h_gen;
  logic [31:0]      h_idx;
  logic             h_bad;
  logic [GEN_W-1:0] gen_inc;
  logic [1:0]       want;

  assign h_low   = hdl_r[31:0];
  assign h_gen   = hdl_r[62:32];
  assign h_idx   = h_low - 32'd1;
  assign h_bad   = hdl_r[63] || (h_low == 32'd0) || (h_gen == '0) ||
                   (h_idx >= 32'(created_r));
  assign gen_inc = (rd_q.gen == GEN_MAX) ? GEN_W'(1) : rd_q.gen + GEN_W'(1);
  assign want    = (act_r == ACT_GET_CTX || act_r == ACT_REL_CTX) ? KIND_CTX : KIND_PRB;

  // slot memories
  always_ff @(posedge clk) begin
    if (we) slot_mem[wr_addr] <= wr_data;
    if (vwe) val_mem[wr_addr] <= pay_r;
    rd_q  <= slot_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    created_nxt = created_r;
    ctx_nxt     = ctx_r;
    prb_nxt     = prb_r;
    alc_nxt     = alc_r;
    rel_nxt     = rel_r;
    st_nxt      = st_r;
    nh_nxt      = nh_r;
    fp_nxt      = fp_r;
    rd_addr     = idx_r;
    we          = 1'b0;
    vwe         = 1'b0;
    wr_addr     = idx_r;
    wr_data     = rd_q;
    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wr_data = '{kind: KIND_FREE, gen: GEN_W'(1), owner: 64'd0};
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(SLOT_COUNT - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          st_nxt  = ST_INVALID;
          nh_nxt  = '0;
          fp_nxt  = '0;
          idx_nxt = '0;
          cnt_nxt = '0;
          if (in_action == ACT_ALLOC_CTX || in_action == ACT_ALLOC_PRB)
            state_nxt = S_SRD;
          else if (in_action > 3'(ACT_REL_CTX))
            state_nxt = S_DONE;
          else
            state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // present handle index to memory
        if (h_bad) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = h_idx[IW-1:0];
          rd_addr   = h_idx[IW-1:0];
          state_nxt = S_CHKW;
        end
      end
      S_CHKW: begin
        state_nxt = S_DONE;
        if (rd_q.gen != h_gen || rd_q.kind == KIND_FREE) begin
          st_nxt = ST_STALE;
        end else if (rd_q.kind != want) begin
          st_nxt = ST_TYPE;
        end else if (want == KIND_PRB && rd_q.owner != own_r) begin
          st_nxt = ST_OWNER;
        end else begin
          st_nxt = ST_OK;
          if (act_r == ACT_GET_CTX || act_r == ACT_GET_PRB) begin
            fp_nxt = val_q;
          end else if (act_r == ACT_REL_PRB) begin
            we      = 1'b1;
            wr_data = '{kind: KIND_FREE, gen: gen_inc, owner: 64'd0};
            rel_nxt = rel_r + 64'd1;
            prb_nxt = prb_r - 7'd1;
          end else begin
            cnt_nxt   = '0;
            rd_addr   = '0;
            state_nxt = S_CSCAN;
          end
        end
      end
      S_SRD: begin
        // read slot cnt_r for free search
        if (cnt_r == created_r) begin
          if (created_r == CW'(SLOT_COUNT)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            created_nxt = created_r + CW'(1);
            idx_nxt     = cnt_r[IW-1:0];
            rd_addr     = cnt_r[IW-1:0];
            state_nxt   = S_ALLOC;
          end
        end else begin
          idx_nxt   = cnt_r[IW-1:0];
          rd_addr   = cnt_r[IW-1:0];
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rd_q.kind == KIND_FREE) begin
          state_nxt = S_ALLOC;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_SRD;
        end
      end
      S_ALLOC: begin
        we      = 1'b1;
        vwe     = 1'b1;
        wr_data = '{kind: (act_r == ACT_ALLOC_CTX) ? KIND_CTX : KIND_PRB,
                    gen: rd_q.gen,
                    owner: (act_r == ACT_ALLOC_CTX) ? 64'd0 : own_r};
        alc_nxt = alc_r + 64'd1;
        if (act_r == ACT_ALLOC_CTX) ctx_nxt = ctx_r + 7'd1;
        else                        prb_nxt = prb_r + 7'd1;
        st_nxt    = ST_OK;
        nh_nxt    = {rd_q.gen, 32'(idx_r) + 32'd1};
        state_nxt = S_DONE;
      end
      S_CSCAN: begin
        // rd_q holds slot cnt_r; address cnt_r+1 issued (idx_r at scan end)
        rd_addr = cnt_r[IW-1:0] + IW'(1);
        wr_addr = cnt_r[IW-1:0];
        if (cnt_r != created_r && rd_q.kind == KIND_PRB && rd_q.owner == hdl_r) begin
          we      = 1'b1;
          wr_data = '{kind: KIND_FREE, gen: gen_inc, owner: 64'd0};
          rel_nxt = rel_r + 64'd1;
          prb_nxt = prb_r - 7'd1;
        end
        if (cnt_r == created_r) begin
          rd_addr   = idx_r;
          state_nxt = S_CFIN;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_CFIN: begin
        we        = 1'b1;
        wr_data   = '{kind: KIND_FREE, gen: gen_inc, owner: 64'd0};
        rel_nxt   = rel_r + 64'd1;
        ctx_nxt   = ctx_r - 7'd1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      idx_r     <= '0;
      cnt_r     <= '0;
      created_r <= '0;
      ctx_r     <= '0;
      prb_r     <= '0;
      alc_r     <= '0;
      rel_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cnt_r     <= cnt_nxt;
      created_r <= created_nxt;
      ctx_r     <= ctx_nxt;
      prb_r     <= prb_nxt;
      alc_r     <= alc_nxt;
      rel_r     <= rel_nxt;
      ov_r      <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    nh_r <= nh_nxt;
    fp_r <= fp_nxt;
    if (state_r == S_IDLE && start) begin
      act_r <= in_action;
      hdl_r <= in_handle;
      own_r <= in_owner;
      pay_r <= in_payload;
    end
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = ov_r;
  assign out_status            = st_r;
  assign out_new_handle        = nh_r;
  assign out_found_payload     = fp_r;
  assign out_live_contexts     = ctx_r;
  assign out_live_probes       = prb_r;
  assign out_allocations_total = alc_r;
  assign out_releases_total    = rel_r;

  a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
    created_r <= CW'(SLOT_COUNT)) else $error("created count overflow");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> (alc_r - $past(alc_r, 2)) <= 64'd1)
    else $error("allocation counter jumped");
  a_full_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_new_handle == '0)
    else $error("handle issued when full");

endmodule
